@@ rtl/core/tdwm_pkg.sv @@
// shared types, constants and width tables for the terminal display width meter
package tdwm_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BEL   = 8'h07;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_CSI   = 8'h5b;
	localparam logic [7:0] CH_OSC   = 8'h5d;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CSI_LO   = 8'h40;
	localparam logic [7:0] CSI_HI   = 8'h7e;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam logic [7:0] LEAD_LO  = 8'hc0;
	localparam logic [7:0] LEAD_3   = 8'he0;
	localparam logic [7:0] LEAD_4   = 8'hf0;
	localparam logic [7:0] LEAD_HI  = 8'hf7;

	localparam int DATA_W  = 8;
	localparam int FIELD_W = 16;
	localparam int OUT_W   = 40;

	localparam logic [0:0] REG_CELL_LIMIT   = 1'b0;
	localparam logic [0:0] REG_LIMIT_ENABLE = 1'b1;

	localparam logic [1:0] END_TEXT  = 2'd0;
	localparam logic [1:0] END_LIMIT = 2'd1;
	localparam logic [1:0] END_NUL   = 2'd2;

	typedef enum logic [2:0] {
		PH_TEXT    = 3'd0,
		PH_ESC     = 3'd1,
		PH_CSI     = 3'd2,
		PH_OSC     = 3'd3,
		PH_OSC_ESC = 3'd4
	} phase_t;

	// what one byte does to the counters: a run of replacement cells, then one char
	typedef struct packed {
		logic [2:0] run_n;
		logic       put_en;
		logic [1:0] put_w;
		logic       nul_stop;
	} action_t;

	typedef struct packed {
		logic [20:0] lo;
		logic [20:0] hi;
	} span_t;

	localparam int N_ZERO = 13;
	localparam int N_WIDE = 14;

	localparam span_t ZERO_SPANS [N_ZERO] = '{
		'{21'h00300, 21'h0036f}, '{21'h00483, 21'h00489}, '{21'h00591, 21'h005bd},
		'{21'h00610, 21'h0061a}, '{21'h0064b, 21'h0065f}, '{21'h00670, 21'h00670},
		'{21'h006d6, 21'h006dc}, '{21'h00e31, 21'h00e31}, '{21'h00e34, 21'h00e3a},
		'{21'h0200b, 21'h0200f}, '{21'h02060, 21'h02064}, '{21'h0fe00, 21'h0fe0f},
		'{21'h0fe20, 21'h0fe2f}
	};

	localparam span_t WIDE_SPANS [N_WIDE] = '{
		'{21'h01100, 21'h0115f}, '{21'h02e80, 21'h0303e}, '{21'h03041, 21'h033ff},
		'{21'h03400, 21'h04dbf}, '{21'h04e00, 21'h09fff}, '{21'h0a000, 21'h0a4cf},
		'{21'h0ac00, 21'h0d7a3}, '{21'h0f900, 21'h0faff}, '{21'h0fe10, 21'h0fe19},
		'{21'h0fe30, 21'h0fe6f}, '{21'h0ff00, 21'h0ff60}, '{21'h0ffe0, 21'h0ffe6},
		'{21'h1f300, 21'h1faff}, '{21'h20000, 21'h3fffd}
	};

	function automatic logic [1:0] cells_of(input logic [20:0] cp);
		logic is_zero;
		logic is_wide;
		is_zero = 1'b0;
		is_wide = 1'b0;
		for (int i = 0; i < N_ZERO; i++) begin
			if (cp >= ZERO_SPANS[i].lo && cp <= ZERO_SPANS[i].hi) is_zero = 1'b1;
		end
		for (int i = 0; i < N_WIDE; i++) begin
			if (cp >= WIDE_SPANS[i].lo && cp <= WIDE_SPANS[i].hi) is_wide = 1'b1;
		end
		if (cp == 21'(CH_TAB)) return 2'd1;
		if (cp < 21'h20 || (cp >= 21'h7f && cp < 21'ha0)) return 2'd0;
		if (is_zero) return 2'd0;
		if (is_wide) return 2'd2;
		return 2'd1;
	endfunction

	function automatic logic [1:0] ascii_cells(input logic [7:0] b);
		if (b == CH_TAB) return 2'd1;
		if (b < 8'h20 || b == CH_DEL) return 2'd0;
		return 2'd1;
	endfunction

endpackage

@@ rtl/core/tdwm_decode.sv @@
// escape skipper and utf-8 collector, turns each byte into a counter action
module tdwm_decode import tdwm_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            byte_in,
	input  logic                  last_in,
	input  logic                  walking,
	input  logic [COUNT_BITS-1:0] at,
	output action_t               act,
	output logic [COUNT_BITS-1:0] run_base,
	output logic [COUNT_BITS-1:0] put_at
);

	phase_t                phase_q, phase_d;
	logic [20:0]           acc_q, acc_d, acc_n;
	logic [1:0]            cont_q, cont_d;
	logic [2:0]            pend_q, pend_d, pend_n;
	logic [COUNT_BITS-1:0] seq_q, seq_d;
	logic                  start_b;
	logic                  cp_ok;

	always_comb begin
		act      = '0;
		run_base = seq_q;
		put_at   = at;
		phase_d  = phase_q;
		acc_d    = acc_q;
		cont_d   = cont_q;
		pend_d   = pend_q;
		seq_d    = seq_q;
		start_b  = 1'b0;
		acc_n    = {acc_q[14:0], byte_in[5:0]};
		pend_n   = pend_q + 3'd1;
		cp_ok    = 1'b0;
		if (walking) begin
			unique case (phase_q)
				PH_ESC: begin
					if (byte_in == CH_NUL) act.nul_stop = 1'b1;
					else if (byte_in == CH_CSI) phase_d = PH_CSI;
					else if (byte_in == CH_OSC) phase_d = PH_OSC;
					else phase_d = PH_TEXT;
				end
				PH_CSI: begin
					if (byte_in == CH_NUL) act.nul_stop = 1'b1;
					else if (byte_in >= CSI_LO && byte_in <= CSI_HI) phase_d = PH_TEXT;
				end
				PH_OSC, PH_OSC_ESC: begin
					if (phase_q == PH_OSC_ESC && byte_in == CH_BSL) phase_d = PH_TEXT;
					else if (byte_in == CH_NUL) act.nul_stop = 1'b1;
					else if (byte_in == CH_BEL) phase_d = PH_TEXT;
					else if (byte_in == CH_ESC) phase_d = PH_OSC_ESC;
					else phase_d = PH_OSC;
				end
				PH_TEXT: begin
					if (cont_q == 2'd0) begin
						start_b = 1'b1;
					end else if (byte_in[7:6] != 2'b10) begin
						// broken sequence: each collected byte becomes a replacement
						act.run_n = pend_q;
						acc_d     = '0;
						cont_d    = 2'd0;
						pend_d    = 3'd0;
						start_b   = 1'b1;
					end else begin
						acc_d  = acc_n;
						pend_d = pend_n;
						cont_d = cont_q - 2'd1;
						if (cont_q == 2'd1) begin
							unique case (pend_n)
								3'd2: cp_ok = acc_n >= 21'h80;
								3'd3: cp_ok = acc_n >= 21'h800 &&
									(acc_n < 21'hd800 || acc_n > 21'hdfff);
								default: cp_ok = acc_n >= 21'h10000 && acc_n <= 21'h10ffff;
							endcase
							if (cp_ok) begin
								act.put_en = 1'b1;
								act.put_w  = cells_of(acc_n);
								put_at     = seq_q;
							end else begin
								act.run_n = pend_n;
							end
							acc_d  = '0;
							pend_d = 3'd0;
						end
					end
				end
				default: phase_d = PH_TEXT;
			endcase
			if (start_b) begin
				if (byte_in == CH_NUL) begin
					act.nul_stop = 1'b1;
				end else if (byte_in == CH_ESC) begin
					phase_d = PH_ESC;
				end else if (byte_in < 8'h80) begin
					act.put_en = 1'b1;
					act.put_w  = ascii_cells(byte_in);
				end else if (byte_in >= LEAD_LO && byte_in <= LEAD_HI) begin
					pend_d = 3'd1;
					seq_d  = at;
					if (byte_in < LEAD_3) begin
						acc_d  = 21'(byte_in[4:0]);
						cont_d = 2'd1;
					end else if (byte_in < LEAD_4) begin
						acc_d  = 21'(byte_in[3:0]);
						cont_d = 2'd2;
					end else begin
						acc_d  = 21'(byte_in[2:0]);
						cont_d = 2'd3;
					end
				end else begin
					act.put_en = 1'b1;
					act.put_w  = 2'd1;
				end
			end
			// sequence cut by end of text
			if (last_in && cont_d != 2'd0) begin
				if (act.run_n == 3'd0) begin
					act.run_n = pend_d;
					run_base  = seq_d;
				end else begin
					act.put_en = 1'b1;
					act.put_w  = 2'd1;
					put_at     = at;
				end
			end
		end
		if (last_in) begin
			phase_d = PH_TEXT;
			acc_d   = '0;
			cont_d  = 2'd0;
			pend_d  = 3'd0;
			seq_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TEXT;
			acc_q   <= '0;
			cont_q  <= 2'd0;
			pend_q  <= 3'd0;
			seq_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cont_q  <= cont_d;
			pend_q  <= pend_d;
			seq_q   <= seq_d;
		end
	end

endmodule

@@ rtl/core/tdwm_meter.sv @@
// width, byte and finish counters with the cell limit check
module tdwm_meter import tdwm_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  last_in,
	input  action_t               act,
	input  logic [COUNT_BITS-1:0] run_base,
	input  logic [COUNT_BITS-1:0] put_at,
	input  logic [FIELD_W-1:0]    cell_limit,
	input  logic                  limit_en,
	output logic                  walking,
	output logic [COUNT_BITS-1:0] at,
	output logic [FIELD_W-1:0]    res_width,
	output logic [FIELD_W-1:0]    res_bytes,
	output logic [1:0]            res_reason
);

	localparam int CB = COUNT_BITS;
	localparam int CW = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;
	localparam logic [CW-1:0] FIELD_MAX = CW'({FIELD_W{1'b1}});

	logic [CB-1:0] width_q, width_d;
	logic [CB-1:0] bytes_q, bytes_d;
	logic [1:0]    fin_q, fin_d;
	logic [CB-1:0] sat_w [7];
	logic [CB:0]   sum_w [7];
	logic [3:0]    stop;
	logic          run_stop;
	logic [2:0]    k;
	logic [2:0]    add_n;
	logic [CB-1:0] wid1;
	logic [CB:0]   base_sum;
	logic [CB:0]   next_sum;
	logic [CB-1:0] base_k;
	logic [CB-1:0] next_at;
	logic          put_stop;
	logic [CW-1:0] ext_w;
	logic [CW-1:0] ext_b;

	assign walking = fin_q == 2'd0;
	assign at      = bytes_q;

	always_comb begin
		for (int i = 0; i < 7; i++) begin
			sum_w[i] = {1'b0, width_q} + (CB+1)'(i);
			sat_w[i] = sum_w[i][CB] ? {CB{1'b1}} : sum_w[i][CB-1:0];
		end
		for (int i = 0; i < 4; i++) begin
			stop[i] = limit_en && (CW'(sat_w[i]) >= CW'(cell_limit));
		end
		run_stop = 1'b0;
		k        = 3'd0;
		for (int i = 3; i >= 0; i--) begin
			if (3'(i) < act.run_n && stop[i]) begin
				run_stop = 1'b1;
				k        = 3'(i);
			end
		end
		wid1     = sat_w[act.run_n];
		put_stop = act.put_en && act.put_w != 2'd0 && limit_en &&
			(CW'(wid1) >= CW'(cell_limit));
		add_n    = act.run_n + (act.put_en ? {1'b0, act.put_w} : 3'd0);
		base_sum = {1'b0, run_base} + (CB+1)'(k);
		base_k   = base_sum[CB] ? {CB{1'b1}} : base_sum[CB-1:0];
		next_sum = {1'b0, bytes_q} + (CB+1)'(1);
		next_at  = next_sum[CB] ? {CB{1'b1}} : next_sum[CB-1:0];

		width_d = width_q;
		bytes_d = bytes_q;
		fin_d   = fin_q;
		if (walking) begin
			if (run_stop) begin
				fin_d   = END_LIMIT;
				bytes_d = base_k;
				width_d = sat_w[k];
			end else if (put_stop) begin
				fin_d   = END_LIMIT;
				bytes_d = put_at;
				width_d = wid1;
			end else if (act.nul_stop) begin
				fin_d   = END_NUL;
				width_d = wid1;
			end else begin
				width_d = sat_w[add_n];
				bytes_d = next_at;
			end
		end

		ext_w      = CW'(width_d);
		ext_b      = CW'(bytes_d);
		res_width  = (ext_w > FIELD_MAX) ? {FIELD_W{1'b1}} : ext_w[FIELD_W-1:0];
		res_bytes  = (ext_b > FIELD_MAX) ? {FIELD_W{1'b1}} : ext_b[FIELD_W-1:0];
		res_reason = fin_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
			bytes_q <= '0;
			fin_q   <= 2'd0;
		end else if (step) begin
			if (last_in) begin
				width_q <= '0;
				bytes_q <= '0;
				fin_q   <= 2'd0;
			end else begin
				width_q <= width_d;
				bytes_q <= bytes_d;
				fin_q   <= fin_d;
			end
		end
	end

endmodule

@@ rtl/core/terminal_display_width_meter.sv @@
// top level: input stage, config registers, decode, counters and result register
// a request is registered in the input stage, and on a last byte its result goes into the result register
// throughput: one byte per cycle but for a held last byte, set by the counter update loop
// a last byte waits in the input stage only while an earlier result is not taken
// reset: asynchronous, clears the walk, the stages and restores the config defaults
module terminal_display_width_meter import tdwm_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DATA_W-1:0]    s_tdata,   // text_byte
	input  logic                 s_tlast,   // end_of_text
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // cell_width, bytes_consumed, end_reason, zero pad
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [FIELD_W-1:0]   cfg_data
);

	logic                  valid_s1;
	logic [DATA_W-1:0]     byte_s1;
	logic                  last_s1;
	logic [FIELD_W-1:0]    cell_limit_q;
	logic                  limit_en_q;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;
	logic                  out_free;
	logic                  step;
	logic                  walking;
	logic [COUNT_BITS-1:0] at;
	logic [COUNT_BITS-1:0] run_base;
	logic [COUNT_BITS-1:0] put_at;
	action_t               act;
	logic [FIELD_W-1:0]    res_width;
	logic [FIELD_W-1:0]    res_bytes;
	logic [1:0]            res_reason;

	assign out_free = !out_valid_q || m_tready;
	assign step     = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || step;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_limit_q <= {FIELD_W{1'b1}};
			limit_en_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CELL_LIMIT:   cell_limit_q <= cfg_data;
				REG_LIMIT_ENABLE: limit_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			out_data_q <= {6'd0, res_reason, res_bytes, res_width};
		end
	end

	tdwm_decode #(
		.COUNT_BITS (COUNT_BITS)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.byte_in  (byte_s1),
		.last_in  (last_s1),
		.walking  (walking),
		.at       (at),
		.act      (act),
		.run_base (run_base),
		.put_at   (put_at)
	);

	tdwm_meter #(
		.COUNT_BITS (COUNT_BITS)
	) u_meter (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.last_in    (last_s1),
		.act        (act),
		.run_base   (run_base),
		.put_at     (put_at),
		.cell_limit (cell_limit_q),
		.limit_en   (limit_en_q),
		.walking    (walking),
		.at         (at),
		.res_width  (res_width),
		.res_bytes  (res_bytes),
		.res_reason (res_reason)
	);

endmodule

@@ rtl/core/tdwm_checker.sv @@
// port-level checks for the terminal display width meter, bound to the top level
module tdwm_checker import tdwm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// a held result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// with no result waiting the input side never stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// every counted cell needs at least one consumed byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] <= m_tdata[31:16])
		else $error("cell width exceeds bytes consumed");

	// a limit stop with a saturated width also has a saturated offset
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] == END_LIMIT |-> m_tdata[15:0] != 16'hffff ||
			m_tdata[31:16] == 16'hffff)
		else $error("limit stop with saturated width and unsaturated offset");

endmodule

bind terminal_display_width_meter tdwm_checker u_tdwm_checker (.*);

@@ verif/terminal_display_width_meter_tb.sv @@
// testbench for the terminal display width meter: directed rows and random strings
`timescale 1ns / 100ps

module terminal_display_width_meter_tb;
	import tdwm_pkg::*;

	localparam int SAT = 65535;
	localparam int N_ZW = 13;
	localparam int N_WD = 14;
	localparam logic [20:0] REPLACEMENT_CP = 21'h0fffd;

	// each span is {lo, hi}
	localparam logic [42*N_ZW-1:0] ZW_TBL = {
		21'h00300, 21'h0036f, 21'h00483, 21'h00489, 21'h00591, 21'h005bd,
		21'h00610, 21'h0061a, 21'h0064b, 21'h0065f, 21'h00670, 21'h00670,
		21'h006d6, 21'h006dc, 21'h00e31, 21'h00e31, 21'h00e34, 21'h00e3a,
		21'h0200b, 21'h0200f, 21'h02060, 21'h02064, 21'h0fe00, 21'h0fe0f,
		21'h0fe20, 21'h0fe2f
	};
	localparam logic [42*N_WD-1:0] WD_TBL = {
		21'h01100, 21'h0115f, 21'h02e80, 21'h0303e, 21'h03041, 21'h033ff,
		21'h03400, 21'h04dbf, 21'h04e00, 21'h09fff, 21'h0a000, 21'h0a4cf,
		21'h0ac00, 21'h0d7a3, 21'h0f900, 21'h0faff, 21'h0fe10, 21'h0fe19,
		21'h0fe30, 21'h0fe6f, 21'h0ff00, 21'h0ff60, 21'h0ffe0, 21'h0ffe6,
		21'h1f300, 21'h1faff, 21'h20000, 21'h3fffd
	};

	typedef struct packed {
		logic [1:0]  reason;
		logic [15:0] consumed;
		logic [15:0] cells;
	} meter_result_t;

	typedef enum logic {ROW_BYTE, ROW_REGS} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		logic [7:0]    data;
		logic          last;
		logic          typed;
		meter_result_t want;
		logic [15:0]   lim;
		logic [15:0]   en;
	} stim_row_t;

	localparam int N_DIR = 29;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [DATA_W-1:0]   s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic                cfg_we;
	logic [0:0]          cfg_index;
	logic [FIELD_W-1:0]  cfg_data;

	meter_result_t want_q [$];
	logic [7:0]    text_q [$];
	stim_row_t     dir_rows [N_DIR];
	int            error_count;
	bit            tx_burst;
	bit            rx_burst;
	bit            sink_hold_req;

	// width predictor state
	phase_t      esc_phase;
	logic [20:0] cp_acc;
	int          cont_left;
	int          pend_bytes;
	int          seq_start;
	int          cells_sum;
	int          offset;
	logic [1:0]  walk_why;
	logic [15:0] lim_cells;
	logic        lim_en;

	terminal_display_width_meter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int sat_inc(input int a, input int b);
		return (a + b > SAT) ? SAT : a + b;
	endfunction

	function automatic int glyph_cells(input logic [20:0] cp);
		int i;
		if (cp == 21'(CH_TAB)) return 1;
		if (cp < 21'h20 || (cp >= 21'(CH_DEL) && cp < 21'ha0)) return 0;
		for (i = 0; i < N_ZW; i++) begin
			if (cp >= ZW_TBL[42*i+21 +: 21] && cp <= ZW_TBL[42*i +: 21]) return 0;
		end
		for (i = 0; i < N_WD; i++) begin
			if (cp >= WD_TBL[42*i+21 +: 21] && cp <= WD_TBL[42*i +: 21]) return 2;
		end
		return 1;
	endfunction

	task automatic restart_walk();
		esc_phase = PH_TEXT;
		cp_acc = '0;
		cont_left = 0;
		pend_bytes = 0;
		seq_start = 0;
		cells_sum = 0;
		offset = 0;
		walk_why = END_TEXT;
	endtask

	task automatic halt_on_nul(input int at);
		walk_why = END_NUL;
		offset = at;
	endtask

	task automatic put_glyph(input logic [20:0] cp, input int at);
		int w;
		if (walk_why != END_TEXT) return;
		w = glyph_cells(cp);
		if (w != 0 && lim_en && cells_sum >= lim_cells) begin
			walk_why = END_LIMIT;
			offset = at;
			return;
		end
		cells_sum = sat_inc(cells_sum, w);
	endtask

	task automatic flush_pending();
		int i;
		for (i = 0; i < pend_bytes; i++) put_glyph(REPLACEMENT_CP, sat_inc(seq_start, i));
		cp_acc = '0;
		cont_left = 0;
		pend_bytes = 0;
	endtask

	task automatic open_byte(input logic [7:0] b, input int at);
		if (b == CH_NUL) begin
			halt_on_nul(at);
		end else if (b == CH_ESC) begin
			esc_phase = PH_ESC;
		end else if (b < 8'h80) begin
			put_glyph(21'(b), at);
		end else if (b >= LEAD_LO && b <= LEAD_HI) begin
			if (b < LEAD_3) begin
				cp_acc = 21'(b[4:0]);
				cont_left = 1;
			end else if (b < LEAD_4) begin
				cp_acc = 21'(b[3:0]);
				cont_left = 2;
			end else begin
				cp_acc = 21'(b[2:0]);
				cont_left = 3;
			end
			pend_bytes = 1;
			seq_start = at;
		end else begin
			put_glyph(REPLACEMENT_CP, at);
		end
	endtask

	task automatic osc_byte(input logic [7:0] b, input int at);
		if (b == CH_NUL) halt_on_nul(at);
		else if (b == CH_BEL) esc_phase = PH_TEXT;
		else if (b == CH_ESC) esc_phase = PH_OSC_ESC;
		else esc_phase = PH_OSC;
	endtask

	task automatic take_byte(input logic [7:0] b, input int at);
		logic ok;
		if (esc_phase != PH_TEXT) begin
			case (esc_phase)
				PH_ESC: begin
					if (b == CH_NUL) halt_on_nul(at);
					else if (b == CH_CSI) esc_phase = PH_CSI;
					else if (b == CH_OSC) esc_phase = PH_OSC;
					else esc_phase = PH_TEXT;
				end
				PH_CSI: begin
					if (b == CH_NUL) halt_on_nul(at);
					else if (b >= CSI_LO && b <= CSI_HI) esc_phase = PH_TEXT;
				end
				PH_OSC: osc_byte(b, at);
				PH_OSC_ESC: begin
					if (b == CH_BSL) esc_phase = PH_TEXT;
					else osc_byte(b, at);
				end
				default: esc_phase = PH_TEXT;
			endcase
			return;
		end
		if (cont_left == 0) begin
			open_byte(b, at);
			return;
		end
		if (b[7:6] != 2'b10) begin
			flush_pending();
			if (walk_why == END_TEXT) open_byte(b, at);
			return;
		end
		cp_acc = {cp_acc[14:0], b[5:0]};
		pend_bytes++;
		cont_left--;
		if (cont_left != 0) return;
		if (pend_bytes == 2) ok = cp_acc >= 21'h80;
		else if (pend_bytes == 3) ok = cp_acc >= 21'h800 && (cp_acc < 21'hd800 || cp_acc > 21'hdfff);
		else ok = cp_acc >= 21'h10000 && cp_acc <= 21'h10ffff;
		if (ok) begin
			put_glyph(cp_acc, seq_start);
			cp_acc = '0;
			cont_left = 0;
			pend_bytes = 0;
		end else begin
			flush_pending();
		end
	endtask

	task automatic meter_step(input logic [7:0] b, input logic last, output logic made,
			output meter_result_t res);
		int at;
		res = '0;
		if (walk_why == END_TEXT) begin
			at = offset;
			take_byte(b, at);
			if (walk_why == END_TEXT) offset = sat_inc(at, 1);
		end
		made = last;
		if (!last) return;
		if (walk_why == END_TEXT && cont_left != 0) flush_pending();
		res.cells = cells_sum[15:0];
		res.consumed = offset[15:0];
		res.reason = walk_why;
		restart_walk();
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic feed_byte(input logic [7:0] b, input logic last, input logic typed,
			input meter_result_t fixed);
		meter_result_t calc;
		logic made;
		send_byte(b, last);
		meter_step(b, last, made, calc);
		if (made) want_q.push_back(typed ? fixed : calc);
	endtask

	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		while (want_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] lim, input logic [15:0] en);
		cfg_we <= 1'b1;
		cfg_index <= REG_CELL_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_index <= REG_LIMIT_ENABLE;
		cfg_data <= en;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		lim_cells = lim;
		lim_en = en[0];
	endtask

	function automatic stim_row_t rb(input logic [7:0] d, input logic l);
		stim_row_t r;
		r = '0;
		r.kind = ROW_BYTE;
		r.data = d;
		r.last = l;
		return r;
	endfunction

	function automatic stim_row_t rt(input logic [7:0] d, input int c, input int n,
			input logic [1:0] why);
		stim_row_t r;
		r = rb(d, 1'b1);
		r.typed = 1'b1;
		r.want.cells = 16'(c);
		r.want.consumed = 16'(n);
		r.want.reason = why;
		return r;
	endfunction

	function automatic stim_row_t rr(input logic [15:0] lim, input logic [15:0] en);
		stim_row_t r;
		r = '0;
		r.kind = ROW_REGS;
		r.lim = lim;
		r.en = en;
		return r;
	endfunction

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom_range(0, 63))};
	endfunction

	function automatic logic [7:0] osc_filler();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255)); while (b == CH_BEL || b == CH_ESC || b == CH_BSL);
		return b;
	endfunction

	function automatic logic [20:0] pick_codepoint();
		logic [41:0] span;
		logic [20:0] cp;
		int t;
		case ($urandom_range(0, 3))
			0, 1: begin
				t = $urandom_range(0, N_ZW + N_WD - 1);
				span = (t < N_ZW) ? ZW_TBL[42*t +: 42] : WD_TBL[42*(t-N_ZW) +: 42];
				case ($urandom_range(0, 3))
					0: cp = span[41:21] - 21'd1;
					1: cp = span[41:21];
					2: cp = span[20:0];
					default: cp = span[20:0] + 21'd1;
				endcase
			end
			2: begin
				case ($urandom_range(0, 10))
					0: cp = 21'h80;
					1: cp = 21'h9f;
					2: cp = 21'ha0;
					3: cp = 21'h7ff;
					4: cp = 21'h800;
					5: cp = 21'hd7ff;
					6: cp = 21'he000;
					7: cp = 21'hfffd;
					8: cp = 21'hffff;
					9: cp = 21'h10000;
					default: cp = 21'h10ffff;
				endcase
			end
			default: begin
				cp = 21'($urandom_range(32'h80, 32'h10ffff));
				if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp ^ 21'h1000;
			end
		endcase
		return cp;
	endfunction

	task automatic push_utf8(input logic [20:0] cp);
		if (cp < 21'h800) begin
			text_q.push_back({3'b110, cp[10:6]});
		end else if (cp < 21'h10000) begin
			text_q.push_back({4'b1110, cp[15:12]});
			text_q.push_back({2'b10, cp[11:6]});
		end else begin
			text_q.push_back({5'b11110, cp[20:18]});
			text_q.push_back({2'b10, cp[17:12]});
			text_q.push_back({2'b10, cp[11:6]});
		end
		text_q.push_back({2'b10, cp[5:0]});
	endtask

	// lead byte with fewer continuations than it needs
	task automatic push_short_sequence();
		int need;
		need = $urandom_range(1, 3);
		case (need)
			1: text_q.push_back(8'($urandom_range(8'hc0, 8'hdf)));
			2: text_q.push_back(8'($urandom_range(8'he0, 8'hef)));
			default: text_q.push_back(8'($urandom_range(8'hf0, LEAD_HI)));
		endcase
		repeat ($urandom_range(0, need - 1)) text_q.push_back(cont_byte());
	endtask

	task automatic add_token();
		int pick;
		int k;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			text_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
		end else if (pick < 35) begin
			k = $urandom_range(0, 31);
			if (k == 0) text_q.push_back(CH_DEL);
			else if (k == int'(CH_ESC)) text_q.push_back(CH_TAB);
			else text_q.push_back(8'(k));
		end else if (pick < 60) begin
			push_utf8(pick_codepoint());
		end else if (pick < 68) begin
			text_q.push_back(CH_ESC);
			text_q.push_back(CH_CSI);
			repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(8'h20, 8'h3f)));
			text_q.push_back(8'($urandom_range(CSI_LO, CSI_HI)));
		end else if (pick < 73) begin
			text_q.push_back(CH_ESC);
			text_q.push_back(CH_OSC);
			repeat ($urandom_range(0, 5)) begin
				if ($urandom_range(0, 7) == 0) text_q.push_back(CH_ESC);
				text_q.push_back(osc_filler());
			end
			if ($urandom_range(0, 1) == 0) begin
				text_q.push_back(CH_BEL);
			end else begin
				text_q.push_back(CH_ESC);
				text_q.push_back(CH_BSL);
			end
		end else if (pick < 77) begin
			text_q.push_back(CH_ESC);
			do k = $urandom_range(1, 255); while (k == int'(CH_CSI) || k == int'(CH_OSC));
			text_q.push_back(8'(k));
		end else if (pick < 83) begin
			if ($urandom_range(0, 1) == 0) text_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
			else text_q.push_back(8'($urandom_range(8'hf8, 8'hff)));
		end else if (pick < 89) begin
			push_short_sequence();
			text_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
		end else if (pick < 94) begin
			case ($urandom_range(0, 4))
				0: text_q.push_back(8'($urandom_range(8'hc0, 8'hc1)));
				1: begin
					text_q.push_back(LEAD_3);
					text_q.push_back(8'($urandom_range(8'h80, 8'h9f)));
				end
				2: begin
					text_q.push_back(LEAD_4);
					text_q.push_back(8'($urandom_range(8'h80, 8'h8f)));
					text_q.push_back(cont_byte());
				end
				3: begin
					text_q.push_back(8'hed);
					text_q.push_back(8'($urandom_range(8'ha0, 8'hbf)));
				end
				default: begin
					if ($urandom_range(0, 1) == 0) begin
						text_q.push_back(8'hf4);
						text_q.push_back(8'($urandom_range(8'h90, 8'hbf)));
					end else begin
						text_q.push_back(8'($urandom_range(8'hf5, LEAD_HI)));
						text_q.push_back(cont_byte());
					end
					text_q.push_back(cont_byte());
				end
			endcase
			text_q.push_back(cont_byte());
		end else if (pick < 95) begin
			text_q.push_back(CH_NUL);
		end else begin
			text_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic build_string(input int max_tokens);
		text_q.delete();
		repeat ($urandom_range(1, max_tokens)) add_token();
		if ($urandom_range(0, 9) == 0) push_short_sequence();
	endtask

	// result checker
	always @(posedge clk) begin
		meter_result_t got;
		meter_result_t exp_r;
		got.cells = m_tdata[15:0];
		got.consumed = m_tdata[31:16];
		got.reason = m_tdata[33:32];
		if (arst_n && m_tvalid && m_tready) begin
			if (want_q.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result: cells %0d bytes %0d reason %0d",
						got.cells, got.consumed, got.reason);
			end else begin
				exp_r = want_q.pop_front();
				if (got.cells !== exp_r.cells || got.consumed !== exp_r.consumed ||
						got.reason !== exp_r.reason) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch: cells %0d/%0d bytes %0d/%0d reason %0d/%0d (exp/got)",
							exp_r.cells, got.cells, exp_r.consumed, got.consumed,
							exp_r.reason, got.reason);
				end
			end
		end
	end

	// result side back-pressure
	initial begin : sink
		int gap;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				gap = 400;
			end else begin
				gap = rx_burst ? 0 : $urandom_range(0, 13);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
		end
	end

	initial begin
		#4_000_000;
		$display("terminal_display_width_meter_tb: errors");
		$finish;
	end

	initial begin
		int bytes_done;
		int toks;
		bit paused;
		error_count = 0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		sink_hold_req = 1'b0;
		paused = 1'b0;
		lim_cells = 16'hffff;
		lim_en = 1'b0;
		restart_walk();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_CELL_LIMIT;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_rows = '{
			rt(8'h41, 1, 1, END_TEXT),
			rt(CH_NUL, 0, 0, END_NUL),
			rt(8'hff, 1, 1, END_TEXT),
			// osc with an esc that is not a terminator, closed by bel
			rb(CH_ESC, 1'b0), rb(CH_OSC, 1'b0), rb(CH_ESC, 1'b0), rb(8'h41, 1'b0),
			rb(CH_BEL, 1'b0),
			rb(8'he4, 1'b0), rb(8'hb8, 1'b0), rb(8'h80, 1'b0),
			// overlong pair, then a broken lead
			rb(8'hc0, 1'b0), rb(8'h80, 1'b0),
			rb(8'he0, 1'b0), rb(8'h41, 1'b0),
			// nul inside csi, trailing byte ignored
			rb(CH_ESC, 1'b0), rb(CH_CSI, 1'b0), rb(CH_NUL, 1'b0), rb(CSI_HI, 1'b1),
			rt(8'hf0, 1, 1, END_TEXT),
			rb(CH_ESC, 1'b0), rb(CH_OSC, 1'b0), rt(CH_TAB, 0, 3, END_TEXT),
			rr(16'd1, 16'hffff),
			rb(8'h42, 1'b0), rb(8'h43, 1'b0), rt(CH_NUL, 1, 1, END_LIMIT),
			// upper bits of the enable write are dropped
			rr(16'hffff, 16'hfffe),
			rb(8'h80, 1'b1)
		};
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REGS) begin
				wait_results_done();
				program_regs(dir_rows[i].lim, dir_rows[i].en);
			end else begin
				feed_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
					dir_rows[i].want);
			end
		end

		for (int p = 0; p < 7; p++) begin
			wait_results_done();
			case (p)
				0: program_regs(16'hffff, 16'd0);
				1: program_regs(16'd0, 16'd1);
				2: program_regs(16'd1, 16'd1);
				3: program_regs(16'($urandom_range(2, 12)), 16'd1);
				4: program_regs(16'($urandom_range(13, 60)), 16'd1);
				5: program_regs(16'hffff, 16'd1);
				default: program_regs(16'($urandom_range(0, 65535)), 16'd0);
			endcase
			// long result stall while requests keep coming
			if (p == 1) sink_hold_req = 1'b1;
			toks = (p == 4) ? 40 : 16;
			bytes_done = 0;
			while (bytes_done < 235) begin
				build_string(toks);
				tx_burst = ($urandom_range(0, 4) == 0);
				foreach (text_q[i]) feed_byte(text_q[i], i == text_q.size() - 1, 1'b0, '0);
				bytes_done += text_q.size();
				if (p == 3 && !paused && bytes_done >= 120) begin
					wait_results_done();
					paused = 1'b1;
				end
			end
		end

		wait_results_done();
		if (error_count == 0) begin
			$display("terminal_display_width_meter_tb: clean");
		end else begin
			$display("terminal_display_width_meter_tb: errors");
		end
		$finish;
	end

endmodule
